/* rtl/lkvc_pkg.sv */
// Package for the LRU key-value cache: sizes, codes and request/response types.
`timescale 1ns / 1ps

package lkvc_pkg;

  // Store geometry
  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W    = IDX_W;
  localparam int FILL_W    = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam int CMP_W     = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;

  // Configuration
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic             REG_CAPACITY = 1'b0;

  // Operation codes
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  // Value returned on a miss and on every set
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic                     func;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } resp_t;

endpackage

/* rtl/lru_key_value_cache_unit.sv */
// Top level of the LRU key-value cache: slot scan sequencer, store and config port.
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// A request is taken when start is high and busy is low. One shared key
// comparator walks the slots one per cycle, then the update state writes
// the slot and updates recency ranks; the response appears on resp
// with done high for exactly one cycle. The receiver cannot stall: done
// is not held after that cycle, though resp keeps its value until the next
// update. busy drops in the done cycle, so a new request can be taken in
// that cycle; none is taken while one is in progress. No clearing pass is
// needed after reset. capacity (APB offset 0, values 0 and above 16 clamp
// to 1 and 16) is to be written by the user only while idle; the block does not enforce it.
module lru_key_value_cache_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  lkvc_pkg::req_t         req,
  output logic                   done,
  output lkvc_pkg::resp_t        resp,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import lkvc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  // Store
  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [DATA_W-1:0] data_mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [RANK_W-1:0] rank [ENTRIES];
  logic [FILL_W-1:0] fill;
  logic [CAP_W-1:0]  capacity;

  // Sequencer
  logic [1:0]       state;
  logic [IDX_W-1:0] scan_idx;
  req_t             req_q;

  // Scan results
  logic              hit_f;
  logic [IDX_W-1:0]  hit_idx;
  logic [RANK_W-1:0] hit_rank;
  logic              any_f;
  logic [IDX_W-1:0]  vic_idx;
  logic [RANK_W-1:0] oldest;
  logic              free_f;
  logic [IDX_W-1:0]  free_idx;

  // Per-cycle compare on the scanned slot
  logic              cur_valid;
  logic              cur_match;
  logic [RANK_W-1:0] cur_rank;
  logic              scan_last;

  assign cur_valid = valid[scan_idx];
  assign cur_rank  = rank[scan_idx];
  assign cur_match = cur_valid && (key_mem[scan_idx] == KEY_W'(req_q.key));
  assign scan_last = (scan_idx == IDX_W'(ENTRIES - 1));

  assign busy = (state != ST_IDLE);

  // Effective capacity, clamped to 1..ENTRIES
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic             full;

  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    full = (CMP_W'(fill) >= cap_eff);
  end

  // Update decision: which slot, and touch or fresh insert
  logic              do_write;
  logic              do_touch;
  logic              do_insert;
  logic [IDX_W-1:0]  tgt;
  logic [RANK_W-1:0] tgt_rank;

  always_comb begin
    do_write  = 1'b0;
    do_touch  = 1'b0;
    do_insert = 1'b0;
    tgt       = hit_idx;
    tgt_rank  = hit_rank;
    if (hit_f) begin
      do_touch = 1'b1;
      do_write = (req_q.func == FUNC_SET);
    end else if (req_q.func == FUNC_SET) begin
      if (full && any_f) begin
        do_touch = 1'b1;
        do_write = 1'b1;
        tgt      = vic_idx;
        tgt_rank = oldest;
      end else if (free_f) begin
        do_insert = 1'b1;
        do_write  = 1'b1;
        tgt       = free_idx;
      end
    end
  end

  // Sequencer and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state    <= ST_SCAN;
            scan_idx <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state <= ST_UPDATE;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Request capture and per-slot scan tracking
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_q  <= req;
      hit_f  <= 1'b0;
      any_f  <= 1'b0;
      free_f <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (!hit_f && cur_match) begin
        hit_f    <= 1'b1;
        hit_idx  <= scan_idx;
        hit_rank <= cur_rank;
      end
      if (cur_valid && (!any_f || cur_rank > oldest)) begin
        any_f   <= 1'b1;
        vic_idx <= scan_idx;
        oldest  <= cur_rank;
      end
      if (!cur_valid && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= scan_idx;
      end
    end
  end

  // Key and data store
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && do_write) begin
      key_mem[tgt]  <= KEY_W'(req_q.key);
      data_mem[tgt] <= DATA_W'(req_q.value);
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      resp.hit <= hit_f;
      if (hit_f && req_q.func == FUNC_GET) begin
        resp.read_value <= data_mem[hit_idx];
      end else begin
        resp.read_value <= MISS_VALUE;
      end
    end
  end

  // Valid bits, recency ranks and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (state == ST_UPDATE) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == tgt) begin
          if (do_touch || do_insert) begin
            rank[i] <= '0;
          end
        end else if (valid[i]) begin
          if (do_insert || (do_touch && rank[i] < tgt_rank)) begin
            rank[i] <= rank[i] + RANK_W'(1);
          end
        end
      end
      if (do_insert) begin
        valid[tgt] <= 1'b1;
        fill       <= fill + FILL_W'(1);
      end
    end
  end

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = 32'(capacity);
    end
  end

endmodule
